// ===== rtl/cbii_pkg.sv =====
// Package for the cubic Bezier implicitization and inversion block.
// Holds status codes and fixed widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbii_pkg;
  localparam int CoefW = 64;
  localparam int ParamIntW = 4;
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/cbii_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
// Depends on cbii_pkg for status codes and the parameter integer width.
`timescale 1ns / 1ps
`default_nettype none
module cbii_div #(
  parameter int NW = 65,
  parameter int QW = 20
) (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic [NW-1:0] num,
  input  wire logic [NW-1:0] den,
  output logic [QW-1:0]      quo,
  output logic [1:0]         status
);
  localparam int RW = NW + QW + 1;
  localparam int FW = QW - cbii_pkg::ParamIntW;  // quotient fraction bits
  logic [RW-1:0] rem [0:QW];
  logic [RW-1:0] dv  [0:QW];
  logic [QW-1:0] qb  [0:QW];
  logic [1:0]    st  [0:QW];
  logic          sat;

  // Saturation: num >= den << 4, compared wide.
  assign sat = ({{(QW+1){1'b0}}, num}) >= ({{(QW+1){1'b0}}, den} << cbii_pkg::ParamIntW);

  always_ff @(posedge clk) begin
    if (adv) begin
      // Scale num so the quotient carries FW fraction bits.
      rem[0] <= {{(QW+1){1'b0}}, num} << FW;
      dv[0]  <= {{(QW+1){1'b0}}, den};
      qb[0]  <= '0;
      if (den == '0) st[0] <= cbii_pkg::ST_ZERO;
      else if (sat) st[0] <= cbii_pkg::ST_SAT;
      else st[0] <= cbii_pkg::ST_VALID;
    end
  end

  // Stage k sets quotient bit QW-1-k by comparing rem against den << (QW-1-k) (bit QW-1 first).
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [RW-1:0] d_sh;
    logic          ge;
    assign d_sh = dv[k] << SH;
    assign ge   = rem[k] >= d_sh;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= ge ? rem[k] - d_sh : rem[k];
        qb[k+1]  <= qb[k] | (ge ? (QW)'(1) << SH : '0);
        dv[k+1]  <= dv[k];
        st[k+1]  <= st[k];
      end
    end
  end

  always_comb begin
    status = st[QW];
    case (st[QW])
      cbii_pkg::ST_ZERO: quo = '0;
      cbii_pkg::ST_SAT:  quo = '1;
      default:           quo = qb[QW];
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/cubic_bezier_implicitize_invert.sv =====
// Cubic Bezier implicitization and point inversion, fully pipelined.
// A request passes through the registered stages 1 to 4, the combinational
// stage 5 and the divider stages; throughput one request per cycle while the
// output is not stalled. A stall freezes the whole pipeline in place.
// Reset (rst, synchronous) clears the stage valid bits only.
// Depends on cbii_pkg and cbii_div.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_implicitize_invert #(
  parameter int COORD_BITS      = 8,
  parameter int QUERY_FRAC_BITS = 8,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [7:0]  ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y,
  input  wire logic signed [7:0]  ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y,
  input  wire logic signed [15:0] query_x, query_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [63:0]      coef_const, coef_x, coef_y, coef_xx, coef_xy,
  output logic signed [63:0]      coef_yy, coef_xxx, coef_xxy, coef_xyy, coef_yyy,
  output logic [PARAM_FRAC_BITS+3:0] param_t,
  output logic [1:0]              param_status
);
  localparam int QW  = PARAM_FRAC_BITS + cbii_pkg::ParamIntW;
  localparam int DL  = QW + 1;  // divider depth
  localparam int LAT = 4 + DL;  // total stages
  // Scaled linear forms: 32 bits hold them for QUERY_FRAC_BITS up to 8.
  localparam int LW  = (QUERY_FRAC_BITS > 8) ? 24 + QUERY_FRAC_BITS : 32;
  localparam int XW  = 2 * LW + 1;
  typedef logic signed [cbii_pkg::CoefW-1:0] s64_t;
  typedef logic signed [11:0] pb_t;    // power basis and small entries
  typedef logic signed [23:0] ent_t;   // m, n and the constant parts of the entries
  typedef logic signed [47:0] pp_t;    // pair products
  typedef logic signed [LW-1:0] lin_t;
  typedef logic signed [XW-1:0] xw_t;

  // Whole pipeline advances together when the output is not held.
  logic adv;
  logic [LAT-1:0] vld;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], in_valid};
  end

  function automatic pb_t sx(input logic [7:0] v);
    return pb_t'($signed(v[COORD_BITS-1:0]));
  endfunction

  // Stage 1: power basis.
  pb_t a3, a2, a1, a0, b3, b2, b1, b0;
  logic signed [15:0] qx1, qy1;
  always_ff @(posedge clk) begin
    if (adv) begin
      a3 <= pb_t'(-sx(ctrl0_x) + 3*sx(ctrl1_x) - 3*sx(ctrl2_x) + sx(ctrl3_x));
      a2 <= pb_t'(3*sx(ctrl0_x) - 6*sx(ctrl1_x) + 3*sx(ctrl2_x));
      a1 <= pb_t'(-3*sx(ctrl0_x) + 3*sx(ctrl1_x));
      a0 <= sx(ctrl0_x);
      b3 <= pb_t'(-sx(ctrl0_y) + 3*sx(ctrl1_y) - 3*sx(ctrl2_y) + sx(ctrl3_y));
      b2 <= pb_t'(3*sx(ctrl0_y) - 6*sx(ctrl1_y) + 3*sx(ctrl2_y));
      b1 <= pb_t'(-3*sx(ctrl0_y) + 3*sx(ctrl1_y));
      b0 <= sx(ctrl0_y);
      qx1 <= query_x;
      qy1 <= query_y;
    end
  end

  // Stage 2: Bezout entries (small products).
  ent_t m, n, o2, p2, q2, r2;
  pb_t o0, o1, q0, q1, r0, r1;
  logic signed [15:0] qx2, qy2;
  always_ff @(posedge clk) begin
    if (adv) begin
      m  <= a3*b2 - a2*b3;
      n  <= a3*b1 - a1*b3;
      o0 <= b3; o1 <= -a3;
      o2 <= a3*b0 - a0*b3;
      p2 <= a3*b0 + a2*b1 - a1*b2 - a0*b3;
      q0 <= b2; q1 <= -a2;
      q2 <= a2*b0 - a0*b2;
      r0 <= b1; r1 <= -a1;
      r2 <= a1*b0 - a0*b1;
      qx2 <= qx1; qy2 <= qy1;
    end
  end

  // Stage 3: pair products and scaled linear forms.
  pp_t oo22, oo02, oo12, oo00, oo01, oo11, no2, no0, no1, nn;
  pp_t mq2, mq0, mq1, mp2, mr0, mr1, mr2;
  ent_t p2s, q2s, r2s;
  lin_t os, ps, qs, ms, ns;
  always_ff @(posedge clk) begin
    if (adv) begin
      oo22 <= o2*o2; oo02 <= o0*o2; oo12 <= o1*o2;
      oo00 <= o0*o0; oo01 <= o0*o1; oo11 <= o1*o1;
      no2 <= n*o2; no0 <= n*o0; no1 <= n*o1; nn <= n*n;
      mq2 <= m*q2; mq0 <= m*q0; mq1 <= m*q1; mp2 <= m*p2;
      mr0 <= m*r0; mr1 <= m*r1; mr2 <= m*r2;
      p2s <= p2; q2s <= q2; r2s <= r2;
      os <= (o2 <<< QUERY_FRAC_BITS) + o0*qx2 + o1*qy2;
      ps <= (p2 <<< QUERY_FRAC_BITS) + o0*qx2 + o1*qy2;
      qs <= (q2 <<< QUERY_FRAC_BITS) + q0*qx2 + q1*qy2;
      ms <= m <<< QUERY_FRAC_BITS;
      ns <= n <<< QUERY_FRAC_BITS;
    end
  end

  // Carry small entries alongside to line up with stage 3 products.
  pb_t o0c, o1c, q0c, q1c, r0_d, r1_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      o0c <= o0; o1c <= o1; q0c <= q0; q1c <= q1;
      r0_d <= r0; r1_d <= r1;
    end
  end

  // Stage 4: implicit coefficients and inversion cross products.
  s64_t c [0:9];
  xw_t num4, den4;
  always_ff @(posedge clk) begin
    if (adv) begin
      c[0] <= -oo22*p2s + 2*no2*q2s - mq2*q2s - nn*r2s + mp2*r2s;
      c[1] <= -oo22*o0c - 2*oo02*p2s + 2*no2*q0c + 2*no0*q2s - 2*mq0*q2s
              - nn*r0_d + mp2*r0_d + mr2*o0c;
      c[2] <= -oo22*o1c - 2*oo12*p2s + 2*no2*q1c + 2*no1*q2s - 2*mq1*q2s
              - nn*r1_d + mp2*r1_d + mr2*o1c;
      c[3] <= -2*oo02*o0c - oo00*p2s + 2*no0*q0c - mq0*q0c + mr0*o0c;
      c[4] <= -2*oo12*o0c - 2*oo02*o1c - 2*oo01*p2s + 2*no1*q0c + 2*no0*q1c
              - 2*mq0*q1c + mr0*o1c + mr1*o0c;
      c[5] <= -2*oo12*o1c - oo11*p2s + 2*no1*q1c - mq1*q1c + mr1*o1c;
      c[6] <= -oo00*o0c;
      c[7] <= -2*oo01*o0c - oo00*o1c;
      c[8] <= -oo11*o0c - 2*oo01*o1c;
      c[9] <= -oo11*o1c;
      num4 <= ns*qs - os*ps;
      den4 <= ms*qs - ns*os;
    end
  end

  // Stage 5: magnitudes into the divider.
  logic [XW-1:0] num5, den5;
  always_comb begin
    num5 = num4[XW-1] ? -num4 : num4;
    den5 = den4[XW-1] ? -den4 : den4;
  end

  cbii_div #(.NW(XW), .QW(QW)) u_div (
    .clk(clk), .adv(adv), .num(num5), .den(den5),
    .quo(param_t), .status(param_status)
  );

  // Delay coefficients to match the divider.
  s64_t cd [0:DL-1][0:9];
  always_ff @(posedge clk) begin
    if (adv) begin
      cd[0] <= c;
      for (int i = 1; i < DL; i++) cd[i] <= cd[i-1];
    end
  end
  assign coef_const = cd[DL-1][0];
  assign coef_x     = cd[DL-1][1];
  assign coef_y     = cd[DL-1][2];
  assign coef_xx    = cd[DL-1][3];
  assign coef_xy    = cd[DL-1][4];
  assign coef_yy    = cd[DL-1][5];
  assign coef_xxx   = cd[DL-1][6];
  assign coef_xxy   = cd[DL-1][7];
  assign coef_xyy   = cd[DL-1][8];
  assign coef_yyy   = cd[DL-1][9];

  ast_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(coef_const))
    else $error("held result changed");
  ast_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && param_status == cbii_pkg::ST_ZERO |-> param_t == '0)
    else $error("zero denominator with nonzero parameter");
  ast_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && param_status == cbii_pkg::ST_SAT |-> param_t == '1)
    else $error("saturation without maximum");
endmodule
`default_nettype wire
